// File: sv/matrix_inverse_4x4_macros.svh
// ----------------------------------------------------------------------------
// matrix_inverse_4x4 assertion macros
// Shorthand for the clocked implication checks used in the intake (mi4_front).
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_4X4_MACROS_SVH
`define MATRIX_INVERSE_4X4_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define MI4_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define MI4_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared constants, types and index tables of the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package mi4_pkg;

	localparam int ELEMENT_WIDTH_DEF = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int MATRIX_ELEMS      = 16;
	localparam int OQ_DEPTH          = 2;

	// back to front: bank free and element read address
	typedef struct packed {
		logic       bank_free;
		logic [3:0] rd_addr;
	} bk_req_t;

	// Element index of factor j of triple product t of cofactor k (k = x*4+y).
	// Even t: a[r0][c0]*a[r1][c1]*a[r2][c2]; odd t: a[r2][c0]*a[r1][c1]*a[r0][c2].
	// Columns rotate once per pair of terms.
	function automatic logic [3:0] term_elem(input logic [3:0] k, input logic [2:0] t,
			input logic [1:0] j);
		logic [1:0] x, y, r0, r1, r2, c0, c1, c2, row, col;
		x  = k[3:2];
		y  = k[1:0];
		r0 = y + 2'd1;
		r1 = y + 2'd2;
		r2 = y + 2'd3;
		case (t[2:1])
			2'd0: begin
				c0 = x + 2'd1; c1 = x + 2'd2; c2 = x + 2'd3;
			end
			2'd1: begin
				c0 = x + 2'd3; c1 = x + 2'd1; c2 = x + 2'd2;
			end
			default: begin
				c0 = x + 2'd2; c1 = x + 2'd3; c2 = x + 2'd1;
			end
		endcase
		case (j)
			2'd0: begin
				row = t[0] ? r2 : r0; col = c0;
			end
			2'd1: begin
				row = r1; col = c1;
			end
			default: begin
				row = t[0] ? r0 : r2; col = c2;
			end
		endcase
		return {row, col};
	endfunction

endpackage

// File: sv/mi4_front.sv
// ----------------------------------------------------------------------------
// mi4_front
// Element intake: two banks of sixteen elements and a two-matrix token queue.
// ----------------------------------------------------------------------------
`include "matrix_inverse_4x4_macros.svh"

module mi4_front import mi4_pkg::*; #(
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [ELEMENT_WIDTH-1:0] element_value,
	output logic                     avail,
	output logic [ELEMENT_WIDTH-1:0] rd_data,
	input  bk_req_t                  req
);

	logic [ELEMENT_WIDTH-1:0] mem_q [2*MATRIX_ELEMS];
	logic [ELEMENT_WIDTH-1:0] rd_data_q;
	logic [3:0]               cnt_q;
	logic [1:0]               tokens_q;
	logic                     wbank_q;
	logic                     rbank_q;
	logic                     wr_en;
	logic                     fill_done;

	assign full      = (tokens_q == 2'd2);
	assign avail     = (tokens_q != 2'd0);
	assign wr_en     = push && !full;
	assign fill_done = wr_en && (cnt_q == 4'd15);
	assign rd_data   = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[{wbank_q, cnt_q}] <= element_value;
		end
		rd_data_q <= mem_q[{rbank_q, req.rd_addr}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			tokens_q <= '0;
			wbank_q  <= 1'b0;
			rbank_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (fill_done) begin
				wbank_q <= !wbank_q;
			end
			if (req.bank_free) begin
				rbank_q <= !rbank_q;
			end
			case ({fill_done, req.bank_free})
				2'b10:   tokens_q <= tokens_q + 2'd1;
				2'b01:   tokens_q <= tokens_q - 2'd1;
				default: tokens_q <= tokens_q;
			endcase
		end
	end

	`MI4_ASSERT_IMP(a_rel_needs_bank, clk, arst_n, req.bank_free, tokens_q != 2'd0, "bank freed while none held")
	`MI4_ASSERT_NXT(a_fill_counts, clk, arst_n, fill_done && !req.bank_free, tokens_q == $past(tokens_q) + 2'd1, "completed matrix not queued")
	`MI4_ASSERT_IMP(a_full_at_start, clk, arst_n, tokens_q == 2'd2, cnt_q == 4'd0, "both banks held mid-fill")

endmodule

// File: sv/mi4_back.sv
// ----------------------------------------------------------------------------
// mi4_back
// Cofactors, determinant and quotients on one bit-serial multiplier and one
// restoring divider.
// ----------------------------------------------------------------------------
module mi4_back import mi4_pkg::*; #(
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     avail,
	input  logic [ELEMENT_WIDTH-1:0] rd_data,
	output bk_req_t                  req,
	input  logic                     oq_full,
	output logic                     oq_push,
	output logic [ELEMENT_WIDTH+1:0] oq_data
);

	localparam int W    = ELEMENT_WIDTH;
	localparam int CW   = 3*W + 3;
	localparam int MW   = 4*W + 3;
	localparam int DW   = 4*W + 5;
	localparam int SH   = 2*FRACTION_BITS;
	localparam int NW   = CW + SH;
	localparam int CNTW = $clog2(NW);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RA   = 4'd1;
	localparam logic [3:0] ST_RB   = 4'd2;
	localparam logic [3:0] ST_LB   = 4'd3;
	localparam logic [3:0] ST_MUL1 = 4'd4;
	localparam logic [3:0] ST_LC   = 4'd5;
	localparam logic [3:0] ST_MUL2 = 4'd6;
	localparam logic [3:0] ST_ACC  = 4'd7;
	localparam logic [3:0] ST_DRA  = 4'd8;
	localparam logic [3:0] ST_DLD  = 4'd9;
	localparam logic [3:0] ST_DMUL = 4'd10;
	localparam logic [3:0] ST_REL  = 4'd11;
	localparam logic [3:0] ST_DSET = 4'd12;
	localparam logic [3:0] ST_DIV  = 4'd13;
	localparam logic [3:0] ST_EMIT = 4'd14;

	logic [3:0]            state_q;
	logic [3:0]            k_q;
	logic [2:0]            t_q;
	logic [1:0]            i_q;
	logic [CNTW-1:0]       bit_q;
	logic [W-1:0]          shf_q;
	logic signed [MW-1:0]  m_q;
	logic signed [MW-1:0]  acc_q;
	logic signed [MW-1:0]  acc_n;
	logic signed [MW-1:0]  pp;
	logic signed [CW-1:0]  sum_q;
	logic signed [CW-1:0]  sum_n;
	logic signed [CW-1:0]  cof_q [MATRIX_ELEMS];
	logic signed [CW-1:0]  cof_rd;
	logic [3:0]            cof_ra;
	logic [CW-1:0]         cof_mag;
	logic [CW-1:0]         cof_shr;
	logic signed [DW-1:0]  det_q;
	logic [DW-1:0]         dmag_q;
	logic                  dzero_q;
	logic                  dneg_q;
	logic [NW-1:0]         num_q;
	logic [DW-1:0]         rem_q;
	logic [DW:0]           rem_sh;
	logic [DW:0]           rem_dif;
	logic                  rem_ge;
	logic [W-1:0]          q_q;
	logic                  ovf_q;
	logic                  neg_q;
	logic [W-1:0]          res;
	logic                  term_sub;

	// shift-add step, sign bit first with negative weight
	always_comb begin
		if (shf_q[W-1]) begin
			pp = (bit_q == CNTW'(W-1)) ? -m_q : m_q;
		end else begin
			pp = '0;
		end
		acc_n = (acc_q <<< 1) + pp;
	end

	assign term_sub = t_q[0] ^ k_q[2] ^ k_q[0];
	assign sum_n    = term_sub ? sum_q - acc_q[CW-1:0] : sum_q + acc_q[CW-1:0];
	assign cof_ra   = (state_q == ST_DLD) ? {i_q, 2'b00} : k_q;
	assign cof_rd   = cof_q[cof_ra];
	assign cof_mag  = cof_rd[CW-1] ? (~cof_rd + 1'b1) : cof_rd;
	assign cof_shr  = cof_mag >> SH;

	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign rem_dif = rem_sh - {1'b0, dmag_q};
	assign rem_ge  = (rem_sh >= {1'b0, dmag_q});

	always_comb begin
		req.bank_free = (state_q == ST_REL);
		case (state_q)
			ST_RA:   req.rd_addr = term_elem(k_q, t_q, 2'd0);
			ST_RB:   req.rd_addr = term_elem(k_q, t_q, 2'd1);
			ST_DRA:  req.rd_addr = {2'b00, i_q};
			default: req.rd_addr = term_elem(k_q, t_q, 2'd2);
		endcase
	end

	// saturate the quotient magnitude to the element range
	always_comb begin
		if (!neg_q) begin
			res = (ovf_q || q_q[W-1]) ? {1'b0, {(W-1){1'b1}}} : q_q;
		end else if (ovf_q || (q_q[W-1] && (|q_q[W-2:0]))) begin
			res = {1'b1, {(W-1){1'b0}}};
		end else begin
			res = ~q_q + 1'b1;
		end
	end

	assign oq_push = (state_q == ST_EMIT) && !oq_full;
	assign oq_data = {res, dzero_q, (k_q == 4'd15)};

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sum_q <= '0;
			end
			ST_RB: begin
				shf_q <= rd_data;
			end
			ST_LB: begin
				m_q   <= {{(MW-W){rd_data[W-1]}}, rd_data};
				acc_q <= '0;
			end
			ST_MUL1, ST_MUL2: begin
				acc_q <= acc_n;
				shf_q <= shf_q << 1;
			end
			ST_LC: begin
				shf_q <= rd_data;
				m_q   <= acc_q;
				acc_q <= '0;
			end
			ST_ACC: begin
				if (t_q == 3'd5) begin
					cof_q[k_q] <= sum_n;
					sum_q      <= '0;
				end else begin
					sum_q <= sum_n;
				end
				det_q <= '0;
			end
			ST_DLD: begin
				shf_q <= rd_data;
				m_q   <= {{(MW-CW){cof_rd[CW-1]}}, cof_rd};
				acc_q <= '0;
			end
			ST_DMUL: begin
				acc_q <= acc_n;
				shf_q <= shf_q << 1;
				if (bit_q == '0) begin
					det_q <= det_q + {{(DW-MW){acc_n[MW-1]}}, acc_n};
				end
			end
			ST_REL: begin
				dzero_q <= (det_q == '0);
				dneg_q  <= det_q[DW-1];
				dmag_q  <= det_q[DW-1] ? (~det_q + 1'b1) : det_q;
			end
			ST_DSET: begin
				if (dzero_q) begin
					neg_q <= cof_rd[CW-1];
					q_q   <= cof_shr[W-1:0];
					ovf_q <= |cof_shr[CW-1:W];
				end else begin
					neg_q <= cof_rd[CW-1] ^ dneg_q;
					num_q <= {cof_mag, {SH{1'b0}}};
					rem_q <= '0;
					q_q   <= '0;
					ovf_q <= 1'b0;
				end
			end
			ST_DIV: begin
				rem_q <= rem_ge ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
				q_q   <= {q_q[W-2:0], rem_ge};
				ovf_q <= ovf_q || q_q[W-1];
				num_q <= num_q << 1;
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			t_q     <= '0;
			i_q     <= '0;
			bit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (avail) begin
						k_q     <= '0;
						t_q     <= '0;
						state_q <= ST_RA;
					end
				end
				ST_RA:   state_q <= ST_RB;
				ST_RB:   state_q <= ST_LB;
				ST_LB: begin
					bit_q   <= CNTW'(W-1);
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= ST_LC;
					end
				end
				ST_LC: begin
					bit_q   <= CNTW'(W-1);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (t_q == 3'd5) begin
						t_q <= '0;
						if (k_q == 4'd15) begin
							i_q     <= '0;
							state_q <= ST_DRA;
						end else begin
							k_q     <= k_q + 4'd1;
							state_q <= ST_RA;
						end
					end else begin
						t_q     <= t_q + 3'd1;
						state_q <= ST_RA;
					end
				end
				ST_DRA:  state_q <= ST_DLD;
				ST_DLD: begin
					bit_q   <= CNTW'(W-1);
					state_q <= ST_DMUL;
				end
				ST_DMUL: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						i_q     <= i_q + 2'd1;
						state_q <= (i_q == 2'd3) ? ST_REL : ST_DRA;
					end
				end
				ST_REL: begin
					k_q     <= '0;
					state_q <= ST_DSET;
				end
				ST_DSET: begin
					bit_q   <= CNTW'(NW-1);
					state_q <= dzero_q ? ST_EMIT : ST_DIV;
				end
				ST_DIV: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!oq_full) begin
						if (k_q == 4'd15) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 4'd1;
							state_q <= ST_DSET;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/mi4_outq.sv
// ----------------------------------------------------------------------------
// mi4_outq
// Small result queue between the back end and the result port.
// ----------------------------------------------------------------------------
module mi4_outq import mi4_pkg::*; #(
	parameter int DATA_WIDTH = ELEMENT_WIDTH_DEF + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  logic [DATA_WIDTH-1:0] wr_data,
	output logic                  oq_full,
	output logic                  empty,
	input  logic                  pop,
	output logic [DATA_WIDTH-1:0] rd_data
);

	localparam int AW = $clog2(OQ_DEPTH);

	logic [DATA_WIDTH-1:0] slot_q [OQ_DEPTH];
	logic [AW-1:0]         wp_q;
	logic [AW-1:0]         rp_q;
	logic [AW:0]           cnt_q;
	logic                  do_pop;

	assign oq_full = (cnt_q == (AW+1)'(OQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_pop  = pop && !empty;
	assign rd_data = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(OQ_DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(OQ_DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			case ({wr, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: sv/matrix_inverse_4x4.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 inverse by adjugate over determinant, signed fixed point.
// ----------------------------------------------------------------------------
//  channel   direction  handshake    payload
//  elements  in         push / full  element_value
//  results   out        pop / empty  result_value, singular, last
//
// Sixteen elements fill one of two banks; the matrix in the other bank may
// be worked on meanwhile, so intake stalls (full) only when both are held.
// Per matrix the back end runs every product through the bit-serial
// multiplier and every quotient through the one-bit-a-step restoring divider.
// A full result queue holds the back end in its emit step; it then resumes.
// Reset clears counters, bank tokens and queue pointers; no clearing pass.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4 import mi4_pkg::*; #(
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic signed [ELEMENT_WIDTH-1:0] element_value,
	output logic                            empty,
	input  logic                            pop,
	output logic signed [ELEMENT_WIDTH-1:0] result_value,
	output logic                            singular,
	output logic                            last
);

	logic                     avail;
	logic [ELEMENT_WIDTH-1:0] elem_rd;
	bk_req_t                  req;
	logic                     oq_full;
	logic                     oq_push;
	logic [ELEMENT_WIDTH+1:0] oq_wdata;
	logic [ELEMENT_WIDTH+1:0] oq_rdata;

	// intake: hold elements in banks, hand finished matrices on
	mi4_front #(
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.element_value(element_value),
		.avail        (avail),
		.rd_data      (elem_rd),
		.req          (req)
	);

	// arithmetic: cofactors, determinant, then one quotient per result
	mi4_back #(
		.ELEMENT_WIDTH(ELEMENT_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.rd_data(elem_rd),
		.req    (req),
		.oq_full(oq_full),
		.oq_push(oq_push),
		.oq_data(oq_wdata)
	);

	// result queue: park finished items until the consumer pops them
	mi4_outq #(
		.DATA_WIDTH(ELEMENT_WIDTH + 2)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (oq_push),
		.wr_data(oq_wdata),
		.oq_full(oq_full),
		.empty  (empty),
		.pop    (pop),
		.rd_data(oq_rdata)
	);

	// split the queued word into its fields
	assign result_value = oq_rdata[ELEMENT_WIDTH+1:2];
	assign singular     = oq_rdata[1];
	assign last         = oq_rdata[0];

endmodule
